### rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the maximal scoring segments block
// Widths, stack geometry, word types and sequencer states.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int JW          = CNT_W + 1;
  localparam int LINK_W      = 6;
  localparam logic [LINK_W-1:0] LINK_NONE = {LINK_W{1'b1}};

  localparam int POS_BITS = 24;
  localparam int END_W    = POS_BITS + 1;
  localparam int SCORE_W  = 16;
  localparam int SUM_W    = 40;
  localparam int XD_W     = SUM_W + 2;
  localparam int MIN_W    = 32;
  localparam int XDROP_W  = 31;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [SUM_W-1:0] NEG_SUM = {1'b1, {(SUM_W-1){1'b0}}};

  // register index, taken from paddr[2]
  localparam logic REG_MIN_SCORE = 1'b0;
  localparam logic REG_XDROP     = 1'b1;

  typedef struct packed {
    logic                      action;
    logic signed [SCORE_W-1:0] score;
  } mss_in_t;

  typedef struct packed {
    logic [POS_BITS-1:0]     seg_start;
    logic [END_W-1:0]        seg_end;
    logic signed [SUM_W-1:0] seg_score;
    logic                    last_of_run;
    logic                    overflow;
  } mss_res_t;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_BREAK,
    KIND_END
  } mss_kind_t;

  typedef struct packed {
    mss_kind_t                 kind;
    logic signed [SCORE_W-1:0] score;
    logic [END_W-1:0]          pos;
  } mss_cmd_t;

  typedef struct packed {
    logic [POS_BITS-1:0]     start;
    logic [END_W-1:0]        end_pos;
    logic signed [SUM_W-1:0] low;
    logic signed [SUM_W-1:0] high;
    logic [LINK_W-1:0]       link;
  } mss_entry_t;

  typedef struct packed {
    logic signed [MIN_W-1:0] min_score;
    logic [XDROP_W-1:0]      xdrop;
  } mss_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FR_MAX,
    ST_WALK,
    ST_JNEG,
    ST_PUSH_CHK,
    ST_PUSH,
    ST_AFTER,
    ST_XD_CLR,
    ST_END_CLR,
    ST_FIN,
    ST_FL_INIT,
    ST_FL_RUN
  } mss_state_t;

endpackage

### rtl/mss_fifo.sv
// ----------------------------------------------------------------------------
// mss_fifo: command queue between front and back
// Small register FIFO; head is shown while not empty.
// ----------------------------------------------------------------------------
module mss_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mss_pkg::mss_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output mss_pkg::mss_cmd_t head
);

  mss_pkg::mss_cmd_t              slot_r [mss_pkg::FIFO_DEPTH];
  logic [mss_pkg::FIFO_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mss_pkg::FIFO_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mss_pkg::FIFO_CW-1:0]    cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full       = (cnt_r == mss_pkg::FIFO_CW'(mss_pkg::FIFO_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/mss_front.sv
// ----------------------------------------------------------------------------
// mss_front: input word intake
// Tracks position, drops scores past the position limit, tags each word.
// ----------------------------------------------------------------------------
module mss_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mss_pkg::mss_in_t  in_data,
  output logic              q_push,
  output mss_pkg::mss_cmd_t q_data,
  input  logic              q_full
);

  logic [mss_pkg::END_W-1:0] pos_r, pos_nxt;
  logic                      accept;
  logic                      at_limit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign at_limit = pos_r[mss_pkg::POS_BITS];

  always_comb begin
    q_data.score = in_data.score;
    q_data.pos   = pos_r;
    q_push       = 1'b0;
    pos_nxt      = pos_r;
    if (in_data.action) begin
      q_data.kind = mss_pkg::KIND_END;
    end else if (in_data.score > 0) begin
      q_data.kind = mss_pkg::KIND_ADD;
    end else begin
      q_data.kind = mss_pkg::KIND_BREAK;
    end
    if (accept) begin
      if (in_data.action) begin
        q_push  = 1'b1;
        pos_nxt = '0;
      end else if (!at_limit) begin
        q_push  = 1'b1;
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

### rtl/mss_back.sv
// ----------------------------------------------------------------------------
// mss_back: run tracking, candidate stack and flush sequencer
// Walks predecessor links, merges candidates, flushes and emits words.
// ----------------------------------------------------------------------------
module mss_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mss_pkg::mss_cfg_t cfg,
  input  logic              head_valid,
  input  mss_pkg::mss_cmd_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output mss_pkg::mss_res_t out_data
);

  // candidate stack
  mss_pkg::mss_entry_t mem [mss_pkg::STACK_DEPTH];
  mss_pkg::mss_entry_t rd_q;
  mss_pkg::mss_entry_t wr_entry;
  logic [mss_pkg::IDX_W-1:0] rd_addr;
  logic                      wr_en;

  mss_pkg::mss_state_t state_r, state_nxt, ret_r, ret_nxt;

  logic                              run_open_r, run_open_nxt;
  logic [mss_pkg::POS_BITS-1:0]      run_start_r, run_start_nxt;
  logic signed [mss_pkg::SUM_W-1:0]  run_total_r, run_total_nxt;
  logic signed [mss_pkg::SUM_W-1:0]  cum_r, cum_nxt;
  logic signed [mss_pkg::SUM_W-1:0]  rmax_r, rmax_nxt;
  logic [mss_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [mss_pkg::JW-1:0]            j_r, j_nxt;
  logic [mss_pkg::CNT_W-1:0]         i_r, i_nxt;
  logic                              ovf_r, ovf_nxt;

  // candidate under construction
  logic [mss_pkg::POS_BITS-1:0]      t_start_r, t_start_nxt;
  logic [mss_pkg::END_W-1:0]         t_end_r, t_end_nxt;
  logic signed [mss_pkg::SUM_W-1:0]  t_low_r, t_low_nxt;
  logic signed [mss_pkg::SUM_W-1:0]  t_high_r, t_high_nxt;
  logic [mss_pkg::LINK_W-1:0]        t_pre_r, t_pre_nxt;

  // one result held back so the last word of an item can be marked
  mss_pkg::mss_res_t pend_r, pend_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  mss_pkg::mss_res_t out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic                              out_free;
  logic signed [mss_pkg::SUM_W-1:0]  s_ext, min_ext, fl_sc;
  logic                              fl_hit, fl_go, fl_last, fin_go;
  logic                              w_neg, w_found, w_merge;
  logic [mss_pkg::JW-1:0]            w_nj, j_top;
  logic signed [mss_pkg::XD_W-1:0]   xd_sum;
  logic                              xd_fire;
  logic                              is_end;
  mss_pkg::mss_res_t                 fl_res;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign s_ext   = mss_pkg::SUM_W'($signed(head.score));
  assign min_ext = mss_pkg::SUM_W'($signed(cfg.min_score));
  assign is_end  = (head.kind == mss_pkg::KIND_END);

  assign fl_sc   = rd_q.high - rd_q.low;
  assign fl_hit  = (fl_sc >= min_ext);
  assign fl_go   = !(fl_hit && pend_valid_r) || out_free;
  assign fl_last = ((i_r + 1'b1) == count_r);
  assign fin_go  = !pend_valid_r || out_free;

  assign fl_res.seg_start   = rd_q.start;
  assign fl_res.seg_end     = rd_q.end_pos;
  assign fl_res.seg_score   = fl_sc;
  assign fl_res.last_of_run = 1'b0;
  assign fl_res.overflow    = ovf_r;

  assign j_top   = {1'b0, count_r} - 1'b1;
  assign w_neg   = j_r[mss_pkg::JW-1];
  assign w_found = (rd_q.low < t_low_r);
  assign w_merge = w_found && (rd_q.high < t_high_r);
  assign w_nj    = (rd_q.link != mss_pkg::LINK_NONE && {1'b0, rd_q.link} < j_r)
                   ? mss_pkg::JW'(rd_q.link) : j_r - 1'b1;

  assign xd_sum  = mss_pkg::XD_W'(cum_r) + mss_pkg::XD_W'(s_ext)
                   + mss_pkg::XD_W'($signed({1'b0, cfg.xdrop}));
  assign xd_fire = (cfg.xdrop != '0) && (xd_sum < mss_pkg::XD_W'(rmax_r));

  assign wr_entry.start   = t_start_r;
  assign wr_entry.end_pos = t_end_r;
  assign wr_entry.low     = t_low_r;
  assign wr_entry.high    = t_high_r;
  assign wr_entry.link    = t_pre_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mss_pkg::ST_IDLE: begin
        if (head_valid && head.kind != mss_pkg::KIND_ADD) begin
          state_nxt = run_open_r ? mss_pkg::ST_FR_MAX : mss_pkg::ST_AFTER;
        end
      end
      mss_pkg::ST_FR_MAX:   state_nxt = mss_pkg::ST_WALK;
      mss_pkg::ST_WALK: begin
        if (w_neg) begin
          state_nxt = mss_pkg::ST_JNEG;
        end else if (w_found && !w_merge) begin
          state_nxt = mss_pkg::ST_PUSH_CHK;
        end
      end
      mss_pkg::ST_JNEG:     state_nxt = mss_pkg::ST_FL_INIT;
      mss_pkg::ST_PUSH_CHK: begin
        state_nxt = (count_r >= mss_pkg::CNT_W'(mss_pkg::STACK_DEPTH))
                    ? mss_pkg::ST_FL_INIT : mss_pkg::ST_PUSH;
      end
      mss_pkg::ST_PUSH:     state_nxt = mss_pkg::ST_AFTER;
      mss_pkg::ST_AFTER: begin
        state_nxt = (is_end || xd_fire) ? mss_pkg::ST_FL_INIT : mss_pkg::ST_FIN;
      end
      mss_pkg::ST_XD_CLR:   state_nxt = mss_pkg::ST_FIN;
      mss_pkg::ST_END_CLR:  state_nxt = mss_pkg::ST_FIN;
      mss_pkg::ST_FIN: begin
        if (fin_go) begin
          state_nxt = mss_pkg::ST_IDLE;
        end
      end
      mss_pkg::ST_FL_INIT: begin
        state_nxt = (count_r == '0) ? ret_r : mss_pkg::ST_FL_RUN;
      end
      mss_pkg::ST_FL_RUN: begin
        if (fl_go && fl_last) begin
          state_nxt = ret_r;
        end
      end
      default: state_nxt = mss_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ret_nxt        = ret_r;
    run_open_nxt   = run_open_r;
    run_start_nxt  = run_start_r;
    run_total_nxt  = run_total_r;
    cum_nxt        = cum_r;
    rmax_nxt       = rmax_r;
    count_nxt      = count_r;
    j_nxt          = j_r;
    i_nxt          = i_r;
    ovf_nxt        = ovf_r;
    t_start_nxt    = t_start_r;
    t_end_nxt      = t_end_r;
    t_low_nxt      = t_low_r;
    t_high_nxt     = t_high_r;
    t_pre_nxt      = t_pre_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    pop            = 1'b0;
    wr_en          = 1'b0;
    rd_addr        = '0;
    case (state_r)
      mss_pkg::ST_IDLE: begin
        if (head_valid) begin
          if (head.kind == mss_pkg::KIND_ADD) begin
            pop = 1'b1;
            if (!run_open_r) begin
              run_open_nxt  = 1'b1;
              run_start_nxt = head.pos[mss_pkg::POS_BITS-1:0];
              run_total_nxt = s_ext;
            end else begin
              run_total_nxt = run_total_r + s_ext;
            end
          end else if (run_open_r) begin
            t_start_nxt = run_start_r;
            t_end_nxt   = head.pos;
            t_low_nxt   = cum_r;
            t_high_nxt  = cum_r + run_total_r;
          end
        end
      end
      mss_pkg::ST_FR_MAX: begin
        if (t_high_r > rmax_r) begin
          rmax_nxt = t_high_r;
        end
        j_nxt   = j_top;
        rd_addr = j_top[mss_pkg::IDX_W-1:0];
      end
      mss_pkg::ST_WALK: begin
        if (!w_neg) begin
          if (w_merge) begin
            t_start_nxt = rd_q.start;
            t_low_nxt   = rd_q.low;
            count_nxt   = j_r[mss_pkg::CNT_W-1:0];
            j_nxt       = j_r - 1'b1;
            rd_addr     = j_nxt[mss_pkg::IDX_W-1:0];
          end else if (w_found) begin
            t_pre_nxt = mss_pkg::LINK_W'(j_r[mss_pkg::CNT_W-1:0]);
          end else begin
            j_nxt   = w_nj;
            rd_addr = w_nj[mss_pkg::IDX_W-1:0];
          end
        end
      end
      mss_pkg::ST_JNEG: begin
        rmax_nxt  = t_high_r;
        t_pre_nxt = mss_pkg::LINK_NONE;
        ovf_nxt   = 1'b0;
        ret_nxt   = mss_pkg::ST_PUSH_CHK;
      end
      mss_pkg::ST_PUSH_CHK: begin
        if (count_r >= mss_pkg::CNT_W'(mss_pkg::STACK_DEPTH)) begin
          t_pre_nxt = mss_pkg::LINK_NONE;
          ovf_nxt   = 1'b1;
          ret_nxt   = mss_pkg::ST_PUSH;
        end
      end
      mss_pkg::ST_PUSH: begin
        wr_en         = 1'b1;
        count_nxt     = count_r + 1'b1;
        cum_nxt       = t_high_r;
        run_open_nxt  = 1'b0;
        run_total_nxt = '0;
      end
      mss_pkg::ST_AFTER: begin
        if (is_end) begin
          ovf_nxt = 1'b0;
          ret_nxt = mss_pkg::ST_END_CLR;
        end else if (xd_fire) begin
          ovf_nxt = 1'b0;
          ret_nxt = mss_pkg::ST_XD_CLR;
        end else begin
          cum_nxt = cum_r + s_ext;
        end
      end
      mss_pkg::ST_XD_CLR: begin
        cum_nxt  = s_ext;
        rmax_nxt = mss_pkg::NEG_SUM;
      end
      mss_pkg::ST_END_CLR: begin
        run_open_nxt  = 1'b0;
        run_start_nxt = '0;
        run_total_nxt = '0;
        cum_nxt       = '0;
        rmax_nxt      = mss_pkg::NEG_SUM;
        count_nxt     = '0;
      end
      mss_pkg::ST_FIN: begin
        if (fin_go) begin
          pop = 1'b1;
          if (pend_valid_r) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt             = pend_r;
            out_data_nxt.last_of_run = 1'b1;
            pend_valid_nxt           = 1'b0;
          end
        end
      end
      mss_pkg::ST_FL_INIT: begin
        i_nxt   = '0;
        rd_addr = '0;
      end
      mss_pkg::ST_FL_RUN: begin
        rd_addr = i_r[mss_pkg::IDX_W-1:0];
        if (fl_go) begin
          if (fl_hit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = pend_r;
            end
            pend_nxt       = fl_res;
            pend_valid_nxt = 1'b1;
          end
          if (fl_last) begin
            count_nxt = '0;
          end else begin
            i_nxt   = i_r + 1'b1;
            rd_addr = i_nxt[mss_pkg::IDX_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mss_pkg::ST_IDLE;
      ret_r        <= mss_pkg::ST_IDLE;
      run_open_r   <= 1'b0;
      run_start_r  <= '0;
      run_total_r  <= '0;
      cum_r        <= '0;
      rmax_r       <= mss_pkg::NEG_SUM;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      run_open_r   <= run_open_nxt;
      run_start_r  <= run_start_nxt;
      run_total_r  <= run_total_nxt;
      cum_r        <= cum_nxt;
      rmax_r       <= rmax_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    ovf_r      <= ovf_nxt;
    t_start_r  <= t_start_nxt;
    t_end_r    <= t_end_nxt;
    t_low_r    <= t_low_nxt;
    t_high_r   <= t_high_nxt;
    t_pre_r    <= t_pre_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[mss_pkg::IDX_W-1:0]] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

endmodule

### rtl/maximal_scoring_segments.sv
// ----------------------------------------------------------------------------
// maximal_scoring_segments: streaming all-maximal-scoring-segments search
// Front tags score/end words, a 4-deep queue decouples it from the back
// sequencer that merges runs on the candidate stack and flushes results.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake               | word
//   --------+-----+-------------------------+---------------------------------
//   in_     | in  | in_valid / in_stall     | mss_in_t  (action, score)
//   out_    | out | out_valid / out_stall   | mss_res_t (segment, flags)
//   cfg     | in  | psel/penable/pwrite/... | min_score @0x0, xdrop @0x4
//
// Sequencing: a positive score is popped straight from idle; a non-positive
// score with no open run passes the after and finish states. Closing a run
// adds the predecessor walk over stack entries and a flush reads each held
// entry in turn, both through the single read port of the stack memory.
// Reset (rst_n low, synchronous) empties queue, stack and run state; the
// stack memory needs no clearing pass. Output stall holds the sequencer only
// when a word must leave; the front keeps filling the queue meanwhile.
// ----------------------------------------------------------------------------
module maximal_scoring_segments (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mss_pkg::mss_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mss_pkg::mss_res_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mss_pkg::ADDR_W-1:0]     paddr,
  input  logic [mss_pkg::DATA_W-1:0]     pwdata,
  output logic [mss_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  mss_pkg::mss_cfg_t cfg_r, cfg_nxt;
  logic              wr_hit;

  mss_pkg::mss_cmd_t q_in, q_head;
  logic              q_push, q_full, q_pop, q_head_valid;

  // configuration registers
  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_hit) begin
      if (paddr[2] == mss_pkg::REG_MIN_SCORE) begin
        cfg_nxt.min_score = pwdata;
      end else begin
        cfg_nxt.xdrop = pwdata[mss_pkg::XDROP_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == mss_pkg::REG_XDROP) begin
      prdata = {1'b0, cfg_r.xdrop};
    end else begin
      prdata = cfg_r.min_score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  mss_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  mss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### tb/sv/mss_checker.sv
// ----------------------------------------------------------------------------
// mss_checker: scoreboard for maximal_scoring_segments
// Snoops the register port and both word channels and predicts the segment
// words from every accepted input word. It then compares each output word
// field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module mss_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  mss_pkg::mss_in_t             in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  mss_pkg::mss_res_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mss_pkg::ADDR_W-1:0]   paddr,
  input  logic [mss_pkg::DATA_W-1:0]   pwdata,
  input  logic                         pready,
  output int                           errors,
  output int                           pending
);

  logic signed [mss_pkg::MIN_W-1:0] min_score_q;
  logic [mss_pkg::XDROP_W-1:0]      xdrop_q;

  logic [mss_pkg::END_W-1:0]        pos;
  bit                               run_open;
  logic [mss_pkg::POS_BITS-1:0]     run_start;
  logic signed [mss_pkg::SUM_W-1:0] run_total;
  logic signed [mss_pkg::SUM_W-1:0] cum;
  logic signed [mss_pkg::SUM_W-1:0] run_max;
  int                               depth_used;
  mss_pkg::mss_entry_t              cand[mss_pkg::STACK_DEPTH];

  mss_pkg::mss_res_t                seg_q[$];

  assign pending = seg_q.size();

  function automatic void clear_seq();
    pos        = '0;
    run_open   = 0;
    run_start  = '0;
    run_total  = '0;
    cum        = '0;
    run_max    = mss_pkg::NEG_SUM;
    depth_used = 0;
  endfunction

  function automatic void flush_cands(bit ovf);
    logic signed [mss_pkg::SUM_W-1:0] sc;
    mss_pkg::mss_res_t r;
    for (int i = 0; i < depth_used; i++) begin
      sc = $signed(cand[i].high) - $signed(cand[i].low);
      if (sc >= min_score_q) begin
        r.seg_start   = cand[i].start;
        r.seg_end     = cand[i].end_pos;
        r.seg_score   = sc;
        r.last_of_run = 1'b0;
        r.overflow    = ovf;
        seg_q.push_back(r);
      end
    end
    depth_used = 0;
  endfunction

  // close the open run and merge it into the candidate stack
  function automatic void close_run();
    logic [mss_pkg::POS_BITS-1:0]     t_start;
    logic signed [mss_pkg::SUM_W-1:0] t_low, t_high;
    logic [mss_pkg::LINK_W-1:0]       t_link, lk;
    int                               j;
    t_start = run_start;
    t_low   = cum;
    t_high  = cum + run_total;
    t_link  = mss_pkg::LINK_NONE;
    if (t_high > run_max) run_max = t_high;
    forever begin
      j = depth_used - 1;
      while (j >= 0) begin
        if ($signed(cand[j].low) < t_low) break;
        lk = cand[j].link;
        j = (lk != mss_pkg::LINK_NONE && int'(lk) < j) ? int'(lk) : j - 1;
      end
      if (j >= 0 && $signed(cand[j].high) < t_high) begin
        t_start    = cand[j].start;
        t_low      = cand[j].low;
        t_link     = cand[j].link;
        depth_used = j;
        continue;
      end
      if (j < 0) begin
        flush_cands(0);
        run_max = t_high;
        t_link  = mss_pkg::LINK_NONE;
      end else begin
        t_link = mss_pkg::LINK_W'(j);
      end
      if (depth_used >= mss_pkg::STACK_DEPTH) begin
        flush_cands(1);
        t_link = mss_pkg::LINK_NONE;
      end
      cand[depth_used].start   = t_start;
      cand[depth_used].end_pos = pos;
      cand[depth_used].low     = t_low;
      cand[depth_used].high    = t_high;
      cand[depth_used].link    = t_link;
      depth_used++;
      break;
    end
    cum       = t_high;
    run_open  = 0;
    run_total = '0;
  endfunction

  function automatic void predict_word(mss_pkg::mss_in_t w);
    int n0;
    logic signed [mss_pkg::SUM_W-1:0] s;
    n0 = seg_q.size();
    s  = mss_pkg::SUM_W'(w.score);
    if (w.action) begin
      if (run_open) close_run();
      flush_cands(0);
      clear_seq();
    end else if (pos < (mss_pkg::END_W'(1) << mss_pkg::POS_BITS)) begin
      if (s > 0) begin
        if (!run_open) begin
          run_open  = 1;
          run_start = pos[mss_pkg::POS_BITS-1:0];
          run_total = '0;
        end
        run_total = run_total + s;
      end else begin
        if (run_open) close_run();
        if (xdrop_q != 0 &&
            longint'(cum) + longint'(s) + longint'(xdrop_q) < longint'(run_max)) begin
          flush_cands(0);
          cum     = '0;
          run_max = mss_pkg::NEG_SUM;
        end
        cum = cum + s;
      end
      pos++;
    end
    if (seg_q.size() > n0) seg_q[seg_q.size()-1].last_of_run = 1'b1;
  endfunction

  always @(posedge clk) begin
    mss_pkg::mss_res_t e;
    if (!rst_n) begin
      min_score_q <= '0;
      xdrop_q     <= '0;
      errors      <= 0;
      clear_seq();
      seg_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == mss_pkg::REG_XDROP) xdrop_q <= pwdata[mss_pkg::XDROP_W-1:0];
        else                                min_score_q <= pwdata[mss_pkg::MIN_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (seg_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t unexpected word: expected none, got %p", $time, out_data);
        end else begin
          e = seg_q.pop_front();
          if (out_data.seg_start !== e.seg_start || out_data.seg_end !== e.seg_end ||
              out_data.seg_score !== e.seg_score ||
              out_data.last_of_run !== e.last_of_run ||
              out_data.overflow !== e.overflow) begin
            errors <= errors + 1;
            $display("%0t mismatch: expected %p, got %p", $time, e, out_data);
          end
        end
      end
      if (in_valid && !in_stall) predict_word(in_data);
    end
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: top level for maximal_scoring_segments
// Sends directed and random score streams in bursts and stalls the output
// side at random. It sweeps the register settings between drained phases.
// The verdict comes from the scoreboard's error count.
// ----------------------------------------------------------------------------
module tb;

  logic                       clk = 0;
  logic                       rst_n = 0;
  logic                       in_valid = 0;
  logic                       in_stall;
  mss_pkg::mss_in_t           in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 0;
  mss_pkg::mss_res_t          out_data;
  logic                       psel = 0;
  logic                       penable = 0;
  logic                       pwrite = 0;
  logic [mss_pkg::ADDR_W-1:0] paddr = '0;
  logic [mss_pkg::DATA_W-1:0] pwdata = '0;
  logic [mss_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  int  errors, pending;
  int  words_sent = 0;
  int  burst_left = 0;
  bit  hold_off = 0;
  int  stall_mode = 0;
  int  cyc = 0;

  maximal_scoring_segments dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mss_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending
  );

  always #5 clk = ~clk;

  // output stall: the pattern switches at random between none, light and
  // heavy; the long hold-off overrides it
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 64 == 0) stall_mode = $urandom_range(0, 2);
    out_stall <= hold_off ||
                 (stall_mode == 1 && $urandom_range(0, 3) == 0) ||
                 (stall_mode == 2 && $urandom_range(0, 3) != 0);
  end

  // long hold-off mid-run: the sender keeps offering, so the queue fills and
  // in_stall must rise
  initial begin
    wait (words_sent >= 130);
    @(posedge clk);
    hold_off <= 1;
    repeat (400) @(posedge clk);
    hold_off <= 0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one word; bursts of random length with random gaps between them
  task automatic send(input logic act, input logic [mss_pkg::SCORE_W-1:0] sc);
    int g;
    if (burst_left == 0) begin
      g = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (g > 0) begin
        in_valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
    burst_left--;
    in_data.action <= act;
    in_data.score  <= sc;
    in_valid       <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic score(input int v);
    send(1'b0, mss_pkg::SCORE_W'(v));
  endtask

  // drain: all predicted words out, then room for queued words that emit
  // nothing (long walks and silent flushes)
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [mss_pkg::DATA_W-1:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  // random stream: mostly small scores so runs and merges happen, sometimes
  // a full 16-bit value, ends of sequence now and then
  task automatic random_seq();
    int len;
    len = $urandom_range(4, 40);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) score($urandom_range(0, 65535));
      else score(int'($urandom_range(0, 45)) - 20);
    end
    if ($urandom_range(0, 2) != 0)
      send(1'b1, mss_pkg::SCORE_W'($urandom_range(0, 65535)));
  endtask

  // staircase: each run ends lower than the last but starts higher, so no
  // merge happens and the candidate stack overflows
  task automatic staircase();
    for (int k = 0; k < 36; k++) begin
      score(200 - 4 * k);
      score(-(198 - 4 * k));
    end
    send(1'b1, '0);
  endtask

  logic [mss_pkg::DATA_W-1:0] ph_min[6] = '{32'h8000_0000, 32'd3, 32'd0, 32'h7fff_ffff,
                                            32'hffff_ffff, 32'd20};
  logic [mss_pkg::DATA_W-1:0] ph_xd[6]  = '{32'h7fff_ffff, 32'd30, 32'd0, 32'd1,
                                            32'd15, 32'd0};

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, zero as a run breaker, empty end, end with open run
    reg_write(mss_pkg::REG_MIN_SCORE, 32'd0);
    reg_write(mss_pkg::REG_XDROP, 32'd0);
    score(32767); score(32767); score(-32768); score(0);
    score(1); score(-1); score(5); score(0); score(3);
    send(1'b1, 16'hffff);
    send(1'b1, 16'h0000);
    score(-5); score(7); score(-2); score(9);
    send(1'b1, 16'h8000);
    score(0); score(-32768); score(32767);
    send(1'b1, 16'h7fff);

    for (int p = 0; p < 6; p++) begin
      drain();
      reg_write(mss_pkg::REG_MIN_SCORE, ph_min[p]);
      reg_write(mss_pkg::REG_XDROP, ph_xd[p]);
      if (p == 2) staircase();
      while (words_sent < 20 + 48 * (p + 1)) random_seq();
    end
    send(1'b1, '0);
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mss_pkg.sv
rtl/mss_fifo.sv
rtl/mss_front.sv
rtl/mss_back.sv
rtl/maximal_scoring_segments.sv
tb/sv/mss_checker.sv
tb/sv/tb.sv
